/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helper functions of the 3x3 box blur unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int SUM_W         = 12;
    localparam int CNT_W         = 4;
    localparam int RECIP_W       = 16;
    localparam int IMG_WIDTH_W   = 11;
    localparam int IMG_HEIGHT_W  = 13;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 13;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef pixel_t [2:0][2:0] window_t;

    // One result to compute: the window rows rlo..2 and columns clo..2.
    typedef struct packed {
        logic [1:0] rlo;
        logic [1:0] clo;
        logic       run_last;
        logic       frame_end;
    } emit_req_t;

    function automatic logic [CNT_W-1:0] neighbor_count(input logic [1:0] rlo,
                                                       input logic [1:0] clo);
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
        rows = CNT_W'(3) - CNT_W'(rlo);
        cols = CNT_W'(3) - CNT_W'(clo);
        return rows * cols;
    endfunction

    // ceil(2^16 / (2n)); exact for every numerator 2*sum+n that can occur.
    function automatic logic [RECIP_W-1:0] recip_mult(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5462;
            4'd9:    m = 16'd3641;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/bb3_line_mem.sv */
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store: one entry per column holding the two rows above the current one.
// ----------------------------------------------------------------------------
module bb3_line_mem
    import bb3_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEF,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [47:0]       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [47:0]       wr_data
);

    logic [47:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/bb3_window.sv */
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 pixel window: shifts one column left and takes a new right column.
// ----------------------------------------------------------------------------
module bb3_window
    import bb3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  pixel_t  above2,
    input  pixel_t  above1,
    input  pixel_t  pix,
    output window_t win
);

    window_t win_reg;
    window_t win_next;

    always_comb
    begin
        win_next = win_reg;
        if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = above2;
            win_next[1][2] = above1;
            win_next[2][2] = pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

/* rtl/bb3_mean.sv */
// ----------------------------------------------------------------------------
// bb3_mean
// Masked window sum, rounded mean by reciprocal multiply, output register.
// ----------------------------------------------------------------------------
module bb3_mean
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  window_t    win,
    input  logic       req_valid,
    input  emit_req_t  req,
    output logic       req_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic       m_tlast,    // run_last
    output logic       m_tuser     // frame_end
);

    logic [SUM_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CNT_W-1:0] n_reg;
    logic             last_reg, fend_reg, s1_valid_reg;

    logic [7:0]       red_reg, green_reg, blue_reg;
    logic             tlast_reg, tuser_reg, m_valid_reg;

    logic             out_free, s1_move, s1_load;
    logic [RECIP_W-1:0] mult;
    logic [7:0]       q_r, q_g, q_b;

    // Row sums first, then the total; pixels outside the frame are masked.
    always_comb
    begin
        logic [SUM_W-1:0] row_r [3];
        logic [SUM_W-1:0] row_g [3];
        logic [SUM_W-1:0] row_b [3];
        for (int i = 0; i < 3; i++)
        begin
            row_r[i] = '0;
            row_g[i] = '0;
            row_b[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (2'(i) >= req.rlo && 2'(j) >= req.clo)
                begin
                    row_r[i] = row_r[i] + SUM_W'(win[i][j].red);
                    row_g[i] = row_g[i] + SUM_W'(win[i][j].green);
                    row_b[i] = row_b[i] + SUM_W'(win[i][j].blue);
                end
            end
        end
        sum_r_next = row_r[0] + row_r[1] + row_r[2];
        sum_g_next = row_g[0] + row_g[1] + row_g[2];
        sum_b_next = row_b[0] + row_b[1] + row_b[2];
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || s1_move;
    assign s1_load   = req_valid && req_ready;

    // floor((2*sum + n) / (2n)) as a multiply by ceil(2^16 / 2n).
    assign mult = recip_mult(n_reg);

    always_comb
    begin
        logic [SUM_W:0]            t_r, t_g, t_b;
        logic [SUM_W+RECIP_W:0]    p_r, p_g, p_b;
        t_r = {sum_r_reg, 1'b0} + (SUM_W+1)'(n_reg);
        t_g = {sum_g_reg, 1'b0} + (SUM_W+1)'(n_reg);
        t_b = {sum_b_reg, 1'b0} + (SUM_W+1)'(n_reg);
        p_r = t_r * mult;
        p_g = t_g * mult;
        p_b = t_b * mult;
        q_r = p_r[RECIP_W+7:RECIP_W];
        q_g = p_g[RECIP_W+7:RECIP_W];
        q_b = p_b[RECIP_W+7:RECIP_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            n_reg     <= neighbor_count(req.rlo, req.clo);
            last_reg  <= req.run_last;
            fend_reg  <= req.frame_end;
        end
        if (s1_move)
        begin
            red_reg   <= q_r;
            green_reg <= q_g;
            blue_reg  <= q_b;
            tlast_reg <= last_reg;
            tuser_reg <= fend_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

/* rtl/box_blur_3x3_stream_unit.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_unit
// Streaming 3x3 box blur of RGB pixels in raster order, rounded half up.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Content
//  s_*       in         s_tvalid / s_tready     one pixel (red, green, blue)
//  m_*       out        m_tvalid / m_tready     blurred pixel, run end, frame end
//  cfg_*     in         cfg_valid / cfg_ready   register index and write data
//
//  A pixel passes through accept (ST_IDLE) and line store read (ST_LOAD), then
//  releases 0 to 4 results in ST_EMIT; no new pixel is taken until all are out.
//  Reset clears the window and the position counters and sets the frame size
//  (640 x 480); the line store is not cleared, since rows outside the frame
//  are masked. A stalled output holds the result stage and then the input.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser,   // frame_end
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_EMIT} state_t;

    state_t                  state_reg;
    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [IMG_HEIGHT_W-1:0] image_height_reg;
    logic [CW-1:0]           col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [CW-1:0]           addr_reg;
    pixel_t                  pix_reg;
    logic [3:0]              pend_reg, pend_next;
    logic [1:0]              rlo_a_reg, rlo_b_reg, clo_a_reg, clo_b_reg;

    logic [CW-1:0]           wm1;
    logic [ROW_W-1:0]        hm1;
    logic                    last_col, last_row, r_ge1, r_ge2, c_ge1, c_ge2;
    logic                    accept, cfg_write;

    logic [47:0]             rd_data;
    pixel_t                  above1, above2;
    window_t                 win;
    logic                    win_load;

    logic [3:0]              low_bit;
    logic [1:0]              k;
    emit_req_t               req;
    logic                    req_valid, req_ready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Last column and row of the frame, with the size clamped to the legal range.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(image_width_reg - 11'd1);
        end
        if (image_height_reg == '0)
        begin
            hm1 = '0;
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = ROW_W'(image_height_reg - 13'd1);
        end
    end

    assign last_col = (col_reg == wm1);
    assign last_row = (row_reg == hm1);
    assign r_ge1    = (row_reg != '0);
    assign r_ge2    = (32'(row_reg) >= 32'd2);
    assign c_ge1    = (col_reg != '0);
    assign c_ge2    = (32'(col_reg) >= 32'd2);

    // Lowest pending result goes next; results leave in raster order.
    assign low_bit  = pend_reg & (~pend_reg + 4'd1);
    always_comb
    begin
        if (pend_reg[0])
        begin
            k = 2'd0;
        end
        else if (pend_reg[1])
        begin
            k = 2'd1;
        end
        else if (pend_reg[2])
        begin
            k = 2'd2;
        end
        else
        begin
            k = 2'd3;
        end
    end

    assign req_valid     = (state_reg == ST_EMIT);
    assign req.rlo       = k[1] ? rlo_b_reg : rlo_a_reg;
    assign req.clo       = k[0] ? clo_b_reg : clo_a_reg;
    assign req.run_last  = ((pend_reg & ~low_bit) == 4'd0);
    assign req.frame_end = (k == 2'd3);
    assign pend_next     = pend_reg & ~low_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data[IMG_WIDTH_W-1:0];
                        col_reg         <= '0;
                        row_reg         <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        image_height_reg <= cfg_data;
                        col_reg          <= '0;
                        row_reg          <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pend_reg  <= {last_row && last_col, last_row && c_ge1,
                                      r_ge1 && last_col, r_ge1 && c_ge1};
                        state_reg <= ST_LOAD;
                        if (last_col)
                        begin
                            col_reg <= '0;
                            row_reg <= last_row ? '0 : row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= (pend_reg != '0) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (req_ready)
                    begin
                        pend_reg <= pend_next;
                        if (pend_next == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= pixel_t'(s_tdata);
            addr_reg  <= col_reg;
            rlo_a_reg <= r_ge2 ? 2'd0 : 2'd1;
            rlo_b_reg <= r_ge1 ? 2'd1 : 2'd2;
            clo_a_reg <= c_ge2 ? 2'd0 : 2'd1;
            clo_b_reg <= c_ge1 ? 2'd1 : 2'd2;
        end
    end

    assign win_load = (state_reg == ST_LOAD);
    assign above2   = pixel_t'(rd_data[23:0]);
    assign above1   = pixel_t'(rd_data[47:24]);

    bb3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (win_load),
        .wr_addr (addr_reg),
        .wr_data ({pix_reg, above1})
    );

    bb3_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (win_load),
        .above2 (above2),
        .above1 (above1),
        .pix    (pix_reg),
        .win    (win)
    );

    bb3_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // The window must not move while results of the previous pixel are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> pend_reg == '0)
        else $error("input accepted with results still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("line store read data not consumed after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wm1 && row_reg <= hm1)
        else $error("position counter outside the frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end result not marked as last of its run");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> pend_reg != '0)
        else $error("emit state with nothing to emit");

endmodule
